[hw/rtl/srd_pkg.sv]
package srd_pkg;

  localparam int AXES   = 2;
  localparam int IN_W   = 16;
  localparam int MAG_W  = 15;
  localparam int THR_W  = 16;
  localparam int CFG_W  = 17;
  localparam int K_W    = 31;
  localparam int S_W    = 31;
  localparam int KA_W   = 46;
  localparam int HALF_W = 23;
  localparam int N_W    = 92;
  localparam int Q_W    = 62;
  localparam int M_W    = 64;
  localparam int R_W    = 32;
  localparam int RM_W   = 34;
  localparam int C_W    = 33;
  localparam int DF_W   = 34;
  localparam int D_W    = 17;
  localparam int DQ_W   = 15;
  localparam int OUT_W  = 16;

  localparam logic [MAG_W-1:0] FULL_COUNT = 15'h7fff;
  localparam logic [D_W-1:0]   ONE_Q16    = 17'h10000;
  localparam logic [IN_W-1:0]  MOST_NEG   = 16'h8000;

  typedef struct packed {
    logic                        dead;
    logic [AXES-1:0]             neg;
    logic [AXES-1:0][MAG_W-1:0]  mag;
    logic [THR_W-1:0]            thr;
  } srd_side_t;

endpackage

[hw/rtl/srd_front.sv]
module srd_front import srd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [IN_W-1:0]             stick_x,
  input  logic [IN_W-1:0]             stick_y,
  input  logic [CFG_W-1:0]            thr,
  output logic                        out_valid,
  output srd_side_t                   out_side,
  output logic [AXES-1:0][N_W-1:0]    n,
  output logic [S_W-1:0]              s
);

  logic [AXES-1:0][IN_W-1:0]  raw;
  logic [AXES-1:0][MAG_W-1:0] mag_next;
  logic [K_W-1:0]             k_next;

  logic                       v1, v2, v3;
  srd_side_t                  side1, side2, side3;
  logic [K_W-1:0]             k1;
  logic [S_W-1:0]             s2, s3;
  logic [AXES-1:0][KA_W-1:0]  ka2;
  logic [2*K_W-1:0]           kk2;
  logic [AXES-1:0][KA_W-1:0]  hh3, hl3, ll3;

  assign raw[0] = stick_x;
  assign raw[1] = stick_y;
  assign k_next = {thr[THR_W-1:0], 15'b0} - {15'b0, thr[THR_W-1:0]};

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (raw[i] == MOST_NEG) begin
        mag_next[i] = FULL_COUNT;
      end else if (raw[i][IN_W-1]) begin
        mag_next[i] = MAG_W'(-raw[i]);
      end else begin
        mag_next[i] = raw[i][MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1.dead <= thr[CFG_W-1];
      side1.thr  <= thr[THR_W-1:0];
      for (int i = 0; i < AXES; i++) begin
        side1.neg[i] <= raw[i][IN_W-1];
        side1.mag[i] <= mag_next[i];
      end
      k1 <= k_next;

      side2 <= side1;
      s2 <= {1'b0, (2*MAG_W)'(side1.mag[0]) * (2*MAG_W)'(side1.mag[0])}
          + {1'b0, (2*MAG_W)'(side1.mag[1]) * (2*MAG_W)'(side1.mag[1])};
      for (int i = 0; i < AXES; i++) begin
        ka2[i] <= {15'b0, k1} * {31'b0, side1.mag[i]};
      end
      kk2 <= {31'b0, k1} * {31'b0, k1};

      side3.neg  <= side2.neg;
      side3.mag  <= side2.mag;
      side3.thr  <= side2.thr;
      side3.dead <= side2.dead | ({1'b0, s2, 32'b0} <= {2'b0, kk2});
      s3 <= s2;
      for (int i = 0; i < AXES; i++) begin
        hh3[i] <= {23'b0, ka2[i][KA_W-1:HALF_W]} * {23'b0, ka2[i][KA_W-1:HALF_W]};
        hl3[i] <= {23'b0, ka2[i][KA_W-1:HALF_W]} * {23'b0, ka2[i][HALF_W-1:0]};
        ll3[i] <= {23'b0, ka2[i][HALF_W-1:0]} * {23'b0, ka2[i][HALF_W-1:0]};
      end

      out_side <= side3;
      s <= s3;
      for (int i = 0; i < AXES; i++) begin
        n[i] <= {hh3[i], 46'b0} + {22'b0, hl3[i], 24'b0} + {46'b0, ll3[i]};
      end
    end
  end

endmodule

[hw/rtl/srd_qdiv.sv]
module srd_qdiv import srd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  srd_side_t                   in_side,
  input  logic [AXES-1:0][N_W-1:0]    n,
  input  logic [S_W-1:0]              s,
  output logic                        out_valid,
  output srd_side_t                   out_side,
  output logic [AXES-1:0][M_W-1:0]    m
);

  logic [Q_W-1:0]                 v_q;
  srd_side_t                      side_q [Q_W];
  logic [S_W-1:0]                 s_q    [Q_W];
  logic [AXES-1:0][Q_W-1:0]       nl_q   [Q_W];
  logic [AXES-1:0][Q_W-1:0]       quo_q  [Q_W];
  logic [AXES-1:0][S_W-1:0]       rem_q  [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    logic                       vin;
    srd_side_t                  sidein;
    logic [S_W-1:0]             sin;
    logic [AXES-1:0][Q_W-1:0]   nin, qin, qnx;
    logic [AXES-1:0][S_W-1:0]   remin, remnx;
    logic [AXES-1:0][S_W:0]     trial;
    logic [AXES-1:0]            ge;

    if (j == 0) begin : g_first
      assign vin    = in_valid;
      assign sidein = in_side;
      assign sin    = s;
      for (genvar i = 0; i < AXES; i++) begin : g_lane
        assign nin[i]   = n[i][Q_W-1:0];
        assign remin[i] = S_W'(n[i][N_W-1:Q_W]);
        assign qin[i]   = '0;
      end
    end else begin : g_next
      assign vin    = v_q[j-1];
      assign sidein = side_q[j-1];
      assign sin    = s_q[j-1];
      assign nin    = nl_q[j-1];
      assign remin  = rem_q[j-1];
      assign qin    = quo_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < AXES; i++) begin
        trial[i] = {remin[i], nin[i][Q_W-1-j]};
        ge[i]    = trial[i] >= {1'b0, sin};
        remnx[i] = ge[i] ? S_W'(trial[i] - {1'b0, sin}) : S_W'(trial[i]);
        qnx[i]   = {qin[i][Q_W-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= sidein;
        s_q[j]    <= sin;
        nl_q[j]   <= nin;
        rem_q[j]  <= remnx;
        quo_q[j]  <= qnx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_q[Q_W-1];
      for (int i = 0; i < AXES; i++) begin
        m[i] <= {2'b0, quo_q[Q_W-1][i]} + {63'b0, |rem_q[Q_W-1][i]};
      end
    end
  end

endmodule

[hw/rtl/srd_isqrt.sv]
module srd_isqrt import srd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  srd_side_t                   in_side,
  input  logic [AXES-1:0][M_W-1:0]    m,
  output logic                        out_valid,
  output srd_side_t                   out_side,
  output logic [AXES-1:0][C_W-1:0]    c
);

  logic [R_W-1:0]                 v_q;
  srd_side_t                      side_q [R_W];
  logic [AXES-1:0][M_W-1:0]       m_q    [R_W];
  logic [AXES-1:0][R_W-1:0]       root_q [R_W];
  logic [AXES-1:0][RM_W-1:0]      rem_q  [R_W];

  for (genvar j = 0; j < R_W; j++) begin : g_step
    logic                       vin;
    srd_side_t                  sidein;
    logic [AXES-1:0][M_W-1:0]   min;
    logic [AXES-1:0][R_W-1:0]   rootin, rootnx;
    logic [AXES-1:0][RM_W-1:0]  remin, remnx;
    logic [AXES-1:0][RM_W+1:0]  trial, test;
    logic [AXES-1:0]            ge;

    if (j == 0) begin : g_first
      assign vin    = in_valid;
      assign sidein = in_side;
      assign min    = m;
      assign rootin = '0;
      assign remin  = '0;
    end else begin : g_next
      assign vin    = v_q[j-1];
      assign sidein = side_q[j-1];
      assign min    = m_q[j-1];
      assign rootin = root_q[j-1];
      assign remin  = rem_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < AXES; i++) begin
        trial[i]  = {remin[i], min[i][M_W-1-2*j -: 2]};
        test[i]   = {2'b0, rootin[i], 2'b01};
        ge[i]     = trial[i] >= test[i];
        remnx[i]  = ge[i] ? RM_W'(trial[i] - test[i]) : RM_W'(trial[i]);
        rootnx[i] = {rootin[i][R_W-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= sidein;
        m_q[j]    <= min;
        root_q[j] <= rootnx;
        rem_q[j]  <= remnx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[R_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_q[R_W-1];
      for (int i = 0; i < AXES; i++) begin
        c[i] <= {1'b0, root_q[R_W-1][i]} + {32'b0, |rem_q[R_W-1][i]};
      end
    end
  end

endmodule

[hw/rtl/srd_scale.sv]
module srd_scale import srd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  srd_side_t                   in_side,
  input  logic [AXES-1:0][C_W-1:0]    c,
  output logic                        out_valid,
  output logic [OUT_W-1:0]            out_x,
  output logic [OUT_W-1:0]            out_y,
  output logic                        in_deadzone
);

  logic                       va, vb;
  srd_side_t                  sidea, sideb;
  logic [AXES-1:0][DF_W-1:0]  diffa;
  logic [D_W-1:0]             da, db;
  logic [AXES-1:0]            zerob, satb;
  logic [AXES-1:0][31:0]      diffb;

  logic [DQ_W-1:0]                v_q;
  srd_side_t                      side_q [DQ_W];
  logic [D_W-1:0]                 d_q    [DQ_W];
  logic [AXES-1:0]                zero_q [DQ_W];
  logic [AXES-1:0]                sat_q  [DQ_W];
  logic [AXES-1:0][DQ_W-1:0]      low_q  [DQ_W];
  logic [AXES-1:0][DQ_W-1:0]      quo_q  [DQ_W];
  logic [AXES-1:0][D_W-1:0]       rem_q  [DQ_W];

  logic [AXES-1:0][DQ_W-1:0]      qv;
  logic [AXES-1:0][OUT_W-1:0]     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sidea <= in_side;
      da    <= ONE_Q16 - {1'b0, in_side.thr};
      for (int i = 0; i < AXES; i++) begin
        diffa[i] <= {3'b0, in_side.mag[i], 16'b0} - {1'b0, c[i]};
      end
      sideb <= sidea;
      db    <= da;
      for (int i = 0; i < AXES; i++) begin
        zerob[i] <= diffa[i][DF_W-1];
        satb[i]  <= ~diffa[i][DF_W-1] & (diffa[i][32:0] >= {1'b0, da, 15'b0});
        diffb[i] <= diffa[i][31:0];
      end
    end
  end

  for (genvar j = 0; j < DQ_W; j++) begin : g_step
    logic                       vin;
    srd_side_t                  sidein;
    logic [D_W-1:0]             din;
    logic [AXES-1:0]            zin, sin;
    logic [AXES-1:0][DQ_W-1:0]  lowin, qin, qnx;
    logic [AXES-1:0][D_W-1:0]   remin, remnx;
    logic [AXES-1:0][D_W:0]     trial;
    logic [AXES-1:0]            ge;

    if (j == 0) begin : g_first
      assign vin    = vb;
      assign sidein = sideb;
      assign din    = db;
      assign zin    = zerob;
      assign sin    = satb;
      assign qin    = '0;
      for (genvar i = 0; i < AXES; i++) begin : g_lane
        assign lowin[i] = diffb[i][DQ_W-1:0];
        assign remin[i] = diffb[i][31:DQ_W];
      end
    end else begin : g_next
      assign vin    = v_q[j-1];
      assign sidein = side_q[j-1];
      assign din    = d_q[j-1];
      assign zin    = zero_q[j-1];
      assign sin    = sat_q[j-1];
      assign qin    = quo_q[j-1];
      assign lowin  = low_q[j-1];
      assign remin  = rem_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < AXES; i++) begin
        trial[i] = {remin[i], lowin[i][DQ_W-1-j]};
        ge[i]    = trial[i] >= {1'b0, din};
        remnx[i] = ge[i] ? D_W'(trial[i] - {1'b0, din}) : D_W'(trial[i]);
        qnx[i]   = {qin[i][DQ_W-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= sidein;
        d_q[j]    <= din;
        zero_q[j] <= zin;
        sat_q[j]  <= sin;
        low_q[j]  <= lowin;
        quo_q[j]  <= qnx;
        rem_q[j]  <= remnx;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (zero_q[DQ_W-1][i]) begin
        qv[i] = '0;
      end else if (sat_q[DQ_W-1][i]) begin
        qv[i] = FULL_COUNT;
      end else begin
        qv[i] = quo_q[DQ_W-1][i];
      end
      if (side_q[DQ_W-1].dead) begin
        res[i] = '0;
      end else if (side_q[DQ_W-1].neg[i]) begin
        res[i] = -{1'b0, qv[i]};
      end else begin
        res[i] = {1'b0, qv[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[DQ_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x       <= res[0];
      out_y       <= res[1];
      in_deadzone <= side_q[DQ_W-1].dead;
    end
  end

endmodule

[hw/rtl/stick_radial_deadzone_top.sv]
// A sample passes through the front end, then the quotient, square root and scaling pipelines.
// Throughput: one sample per cycle unless the output stalls; the 62-step quotient pipeline,
// the 32-step square root pipeline and the 15-step scaling divider retire one step per stage.
// A stall on the output holds the whole pipeline in place.
// Reset (synchronous, active high) empties the pipeline and sets the threshold to zero.
module stick_radial_deadzone_top import srd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // stick_x [15:0], stick_y [31:16]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // out_x [15:0], out_y [31:16]
  output logic              m_axis_tuser    // in_deadzone
);

  logic                       threshold;
  logic [CFG_W-1:0]           deadzone_threshold;
  logic                       en;
  logic                       f_valid, q_valid, r_valid;
  srd_side_t                  f_side, q_side, r_side;
  logic [AXES-1:0][N_W-1:0]   f_n;
  logic [S_W-1:0]             f_s;
  logic [AXES-1:0][M_W-1:0]   q_m;
  logic [AXES-1:0][C_W-1:0]   r_c;
  logic [OUT_W-1:0]           out_x, out_y;

  assign threshold     = 1'b0;
  assign en            = m_axis_tready | ~m_axis_tvalid | threshold;
  assign s_axis_tready = en;
  assign m_axis_tdata  = {out_y, out_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_threshold <= '0;
    end else if (cfg_wr_en) begin
      deadzone_threshold <= cfg_wr_data;
    end
  end

  srd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .stick_x   (s_axis_tdata[15:0]),
    .stick_y   (s_axis_tdata[31:16]),
    .thr       (deadzone_threshold),
    .out_valid (f_valid),
    .out_side  (f_side),
    .n         (f_n),
    .s         (f_s)
  );

  srd_qdiv u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .n         (f_n),
    .s         (f_s),
    .out_valid (q_valid),
    .out_side  (q_side),
    .m         (q_m)
  );

  srd_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .in_side   (q_side),
    .m         (q_m),
    .out_valid (r_valid),
    .out_side  (r_side),
    .c         (r_c)
  );

  srd_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (r_valid),
    .in_side     (r_side),
    .c           (r_c),
    .out_valid   (m_axis_tvalid),
    .out_x       (out_x),
    .out_y       (out_y),
    .in_deadzone (m_axis_tuser)
  );

endmodule

[hw/rtl/srd_checker.sv]
module srd_checker import srd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [31:0]       m_axis_tdata,
  input logic              m_axis_tuser
);

  // A deadzone result carries zero on both axes.
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'h0)
    else $error("deadzone result with non-zero data");

  // Saturation stops at full scale, so the most negative code never appears.
  a_no_most_neg: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] != MOST_NEG && m_axis_tdata[31:16] != MOST_NEG)
    else $error("output reached the most negative code");

  // A stalled result stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The input side is ready whenever the output side has room.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready || !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output had room");

  // Reset leaves no result behind.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

endmodule

bind stick_radial_deadzone_top srd_checker u_srd_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import srd_pkg::*;

  typedef struct {
    logic [15:0] sx;
    logic [15:0] sy;
    bit          hold;
  } sample_t;

  typedef struct {
    logic [15:0] ox;
    logic [15:0] oy;
    logic        dz;
  } stick_out_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             m_axis_tuser;

  sample_t    sample_q[$];
  stick_out_t shaped_q[$];
  logic [16:0] thr_copy = '0;
  int errors = 0;
  bit taken = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int ready_mode = 0;
  bit stim_done = 0;

  stick_radial_deadzone_top dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_axis(logic [15:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v < -32767) v = -32767;
    return v;
  endfunction

  function automatic bit within_scale(longint q, longint a, longint s, longint t, longint d);
    logic [127:0] diff, r, lhs, rhs;
    longint base, sub;
    base = 65536 * a;
    sub = q * d;
    if (sub > base) return 0;
    diff = 128'(base - sub);
    r = 128'(32767 * t * a);
    if (diff == 0) return r == 0;
    lhs = 128'(s) * diff * diff;
    rhs = r * r;
    return lhs >= rhs;
  endfunction

  function automatic logic [15:0] scale_count(longint v, longint s, longint t);
    longint a, lo, hi, mid;
    a = (v < 0) ? -v : v;
    lo = 0;
    hi = 32767;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (within_scale(mid, a, s, t, 65536 - t)) lo = mid;
      else hi = mid - 1;
    end
    if (v < 0) lo = -lo;
    return lo[15:0];
  endfunction

  function automatic stick_out_t shape_sample(logic [15:0] sx, logic [15:0] sy,
                                              logic [16:0] thr);
    stick_out_t r;
    longint x, y, s, t;
    logic [63:0] lhs, rr;
    x = clamp_axis(sx);
    y = clamp_axis(sy);
    t = longint'(thr);
    s = x * x + y * y;
    r.ox = '0;
    r.oy = '0;
    r.dz = 1'b1;
    if (t < 65536) begin
      lhs = 64'(s) << 32;
      rr = 64'(32767 * t);
      if (lhs > rr * rr) begin
        r.ox = scale_count(x, s, t);
        r.oy = scale_count(y, s, t);
        r.dz = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    taken = 0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      shaped_q = {shaped_q,
                  shape_sample(s_axis_tdata[15:0], s_axis_tdata[31:16], thr_copy)};
      void'(sample_q.pop_front());
      taken = 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (sample_q.size() == 0 || (sample_q[0].hold && shaped_q.size() != 0)) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (burst_left == 0) begin
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {sample_q[0].sy, sample_q[0].sx};
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(5, 60);
      ready_mode = $urandom_range(0, 3);
    end
    stall_left--;
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 1) != 0);
      default: m_axis_tready <= (stall_left % 4 == 0);
    endcase
  end

  always @(posedge clk) begin
    stick_out_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (shaped_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected transfer: x=%0d y=%0d dz=%0b",
          $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]), m_axis_tuser);
      end else begin
        e = shaped_q.pop_front();
        if (m_axis_tdata[15:0] !== e.ox || m_axis_tdata[31:16] !== e.oy ||
            m_axis_tuser !== e.dz) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected x=%0d y=%0d dz=%0b, got x=%0d y=%0d dz=%0b",
              $signed(e.ox), $signed(e.oy), e.dz, $signed(m_axis_tdata[15:0]),
              $signed(m_axis_tdata[31:16]), m_axis_tuser);
        end
      end
    end
  end

  task automatic add_sample(int x, int y, bit hold = 0);
    sample_t it;
    it.sx = x[15:0];
    it.sy = y[15:0];
    it.hold = hold;
    sample_q = {sample_q, it};
  endtask

  task automatic add_random(int n, logic [16:0] thr);
    int r, len, m, x, y;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 9);
      if (m < 4) begin
        x = $urandom_range(0, 65535);
        y = $urandom_range(0, 65535);
      end else if (m < 7) begin
        len = (int'(thr) * 32767) / 65536 + $urandom_range(0, 200) - 100;
        if (len < 0) len = 0;
        if (len > 32767) len = 32767;
        r = $urandom_range(0, len);
        x = $urandom_range(0, 1) ? r : -r;
        r = $urandom_range(0, len);
        y = $urandom_range(0, 1) ? r : -r;
      end else if (m < 8) begin
        x = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 30) : -32768 + $urandom_range(0, 30);
        y = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 30) : -32768 + $urandom_range(0, 30);
      end else begin
        x = $urandom_range(0, 64) - 32;
        y = $urandom_range(0, 64) - 32;
      end
      add_sample(x, y, (i == n / 2));
    end
  endtask

  task automatic set_threshold(logic [16:0] v);
    wait (sample_q.size() == 0 && shaped_q.size() == 0);
    repeat (130) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    thr_copy = v;
  endtask

  initial begin
    logic [16:0] thr_set[7];
    thr_set = '{17'd0, 17'd32768, 17'd65535, 17'd65536, 17'd131071, 17'd1, 17'd0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    add_sample(0, 0);
    add_sample(32767, 32767);
    add_sample(-32768, -32768);
    add_sample(32767, 0);
    add_sample(0, -32768);
    add_sample(-32768, 32767);
    add_sample(1, 0);
    add_sample(-1, -1);
    add_sample(23170, 23170);
    add_sample(-12345, 6789);
    set_threshold(17'd32768);
    add_sample(0, 0);
    add_sample(16383, 0);
    add_sample(16384, 0);
    add_sample(0, -16384);
    add_sample(11585, 11585);
    add_sample(-32768, 0);
    add_sample(32767, -32768);
    add_sample(20000, 1);
    for (int p = 0; p < 7; p++) begin
      set_threshold(p == 6 ? 17'($urandom_range(1, 65535)) : thr_set[p]);
      add_random((thr_copy >= 17'd65536) ? 40 : 110, thr_copy);
    end
    wait (sample_q.size() == 0 && shaped_q.size() == 0);
    repeat (130) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
